[design/prsw_pkg.sv]
// Package for the pulse-rate sliding window block.
// Holds the payload structs and fixed field widths; no dependencies.
package prsw_pkg;

  localparam int unsigned IDX_W = 6;   // second index width
  localparam int unsigned CPS_W = 8;   // counts per second width
  localparam int unsigned CPM_W = 14;  // counts per minute width

  localparam logic [CPS_W-1:0] PULSE_MAX = {CPS_W{1'b1}};

  // command codes
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] second_index;
  } in_item_t;

  typedef struct packed {
    logic [CPS_W-1:0] counts_this_second;
    logic [CPM_W-1:0] counts_per_minute;
  } out_item_t;

endpackage

[design/prsw_slot_mem.sv]
// Window slot store: one write port, one registered read port.
// Per-entry valid bits give a cleared store right after reset. Uses prsw_pkg.
module prsw_slot_mem
  import prsw_pkg::*;
#(
  parameter int unsigned DEPTH = 60,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [CPS_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [CPS_W-1:0] wr_data
);

  logic [CPS_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [CPS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // read-before-write: a same-edge write is not seen here
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/pulse_rate_sliding_window.sv]
// Top level of the pulse-rate sliding window block.
// Uses prsw_pkg and prsw_slot_mem.
//
// Counts detector pulses and, on every one-second tick, stores the second's
// count (saturated at 255) in the window slot named by the tick's second
// index and reports that count together with the running sum of all window
// slots (counts per minute). One input transfer is taken every cycle, pulses
// and ticks alike, even back to back, while output back-pressure holds no tick
// in the update stage. A pulse gives no result. A tick's slot read is
// registered together with the tick in the update stage; the updated sum then
// goes to the output register when that is free or drained. The running sum is
// updated as sum - old slot + new count; a tick that reuses the slot of the
// tick right before it gets the just-written value by forwarding around the
// store's read port. A tick whose index is WINDOW_LEN or more writes no slot
// and reports the unchanged sum. The store is usable straight out of reset
// (per-slot valid bits), so no clearing pass is needed. Throughput is
// limited only by output back-pressure.
module pulse_rate_sliding_window
  import prsw_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 60
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned XW = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned CW = 9;  // holds WINDOW_LEN up to 511
  localparam logic [CW-1:0] WIN_LEN_C = CW'(WINDOW_LEN);

  // input side
  logic in_fire, tick_fire, pulse_fire;
  logic [XW-1:0] idx_ext;
  logic [AW-1:0] in_addr;
  logic in_inrange;

  // pulse counter
  logic [CPS_W-1:0] pulse_cnt_r, pulse_cnt_nxt;

  // update stage
  logic             s1_valid_r;
  logic [CPS_W-1:0] s1_cps_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_inrange_r;
  logic             s1_fwd_r;
  logic [CPS_W-1:0] s1_fwd_data_r;
  logic             s1_adv;

  // window store ports
  logic             wr_en;
  logic [CPS_W-1:0] rd_data;
  logic [CPS_W-1:0] old_slot;

  // running sum and output register
  logic [CPM_W-1:0] sum_r, sum_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  assign in_fire    = in_valid && in_ready;
  assign tick_fire  = in_fire && (in_data.command == CMD_TICK);
  assign pulse_fire = in_fire && (in_data.command == CMD_PULSE);

  assign idx_ext    = XW'(in_data.second_index);
  assign in_addr    = idx_ext[AW-1:0];
  assign in_inrange = (CW'(in_data.second_index) < WIN_LEN_C);

  // stage 1 moves on when the output register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // saturating pulse counter, cleared by each tick
  always_comb begin
    pulse_cnt_nxt = pulse_cnt_r;
    if (tick_fire) begin
      pulse_cnt_nxt = '0;
    end else if (pulse_fire && (pulse_cnt_r != PULSE_MAX)) begin
      pulse_cnt_nxt = pulse_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_cnt_r <= '0;
    end else begin
      pulse_cnt_r <= pulse_cnt_nxt;
    end
  end

  assign wr_en = s1_adv && s1_inrange_r;

  prsw_slot_mem #(
    .DEPTH (WINDOW_LEN),
    .AW    (AW)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tick_fire),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (s1_cps_r)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= tick_fire;
    end
  end

  // stage 1 payload; note a write landing on the same slot at the read edge
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_cps_r      <= pulse_cnt_r;
      s1_addr_r     <= in_addr;
      s1_inrange_r  <= in_inrange;
      s1_fwd_r      <= wr_en && (s1_addr_r == in_addr);
      s1_fwd_data_r <= s1_cps_r;
    end
  end

  assign old_slot = s1_fwd_r ? s1_fwd_data_r : rd_data;
  assign sum_nxt  = sum_r - CPM_W'(old_slot) + CPM_W'(s1_cps_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (wr_en) begin
      sum_r <= sum_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.counts_this_second <= s1_cps_r;
      out_data_r.counts_per_minute  <= s1_inrange_r ? sum_nxt : sum_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a tick always leaves the pulse counter at zero
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> (pulse_cnt_r == '0))
    else $error("pulse counter not cleared by tick");

  // at most 64 reachable slots of 255 each
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= CPM_W'(16320))
    else $error("running sum out of range");

  // only in-range slots are ever written
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(s1_addr_r) < WIN_LEN_C))
    else $error("window write beyond last slot");

  // a stalled update stage keeps its tick
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_cps_r)
                                 && $stable(s1_addr_r)))
    else $error("update stage lost a stalled tick");

  // every tick that leaves stage 1 fills the output register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("tick result not registered");

endmodule

[tb/tb_pulse_rate_sliding_window.sv]
// Self-checking testbench for pulse_rate_sliding_window.
// Depends on prsw_pkg and the block's RTL; a built-in window predictor
// checks every tick reading.
`timescale 1ns / 100ps

module tb_pulse_rate_sliding_window;
  import prsw_pkg::*;

  localparam int SLOTS       = 60;      // window length used for the instance
  localparam int CYCLE_LIMIT = 200000;  // several times the slowest legal run

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel: driven on the falling edge
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_item_t in_data  = '0;

  // result channel
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // idling knobs, in percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // predictor state: pulses this second, per-second window, running minute sum
  logic [CPS_W-1:0] pulse_tally;
  logic [CPS_W-1:0] slot_counts [SLOTS];
  logic [CPM_W-1:0] minute_sum;
  out_item_t        pending_readings [$];

  // bookkeeping
  int        cycle_cnt      = 0;
  int        mismatch_count = 0;
  int        xfers_sent     = 0;
  int        ticks_sent     = 0;
  int        stray_ticks    = 0;  // ticks with an index past the window
  int        readings_seen  = 0;
  int        peak_cps       = 0;
  int        sweep_sec      = 0;  // next second of a well-formed minute
  out_item_t want;

  pulse_rate_sliding_window #(
    .WINDOW_LEN(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding",
               cycle_cnt, pending_readings.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int exp);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, exp);
  endtask

  // Advance the predictor by one accepted transfer. A pulse bumps the
  // saturating tally; a tick closes the second and queues its reading.
  function automatic void track_transfer(input in_item_t item);
    out_item_t r;
    if (item.command == CMD_PULSE) begin
      if (pulse_tally != PULSE_MAX) pulse_tally = pulse_tally + 1'b1;
    end else begin
      r.counts_this_second = pulse_tally;
      if (item.second_index < SLOTS) begin
        // running sum: drop the slot's old second, add the new one
        minute_sum = minute_sum - slot_counts[item.second_index] + pulse_tally;
        slot_counts[item.second_index] = pulse_tally;
      end else begin
        stray_ticks++;  // index off the end: no slot write, sum held
      end
      r.counts_per_minute = minute_sum;
      pending_readings.push_back(r);
      if (pulse_tally > peak_cps) peak_cps = pulse_tally;
      pulse_tally = '0;
      ticks_sent++;
    end
  endfunction

  // Compare each reading taken by the receiver against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with nothing pending, cps",
                        out_data.counts_this_second, 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_data.counts_this_second !== want.counts_this_second)
          report_mismatch("counts_this_second", out_data.counts_this_second,
                          want.counts_this_second);
        if (out_data.counts_per_minute !== want.counts_per_minute)
          report_mismatch("counts_per_minute", out_data.counts_per_minute,
                          want.counts_per_minute);
      end
    end
  end

  // One transfer on the input channel. Entered and left at a falling edge;
  // valid is only dropped during an idle gap, so back-to-back transfers
  // keep it high without a glitch.
  task automatic send_event(input logic cmd, input logic [IDX_W-1:0] idx);
    in_item_t item;
    item.command      = cmd;
    item.second_index = idx;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    track_transfer(item);
    xfers_sent++;
    @(negedge clk);
  endtask

  // Pulses carry a random, ignored index so every index bit toggles.
  task automatic send_pulses(input int n);
    repeat (n) send_event(CMD_PULSE, IDX_W'($urandom_range(63)));
  endtask

  // Hold off the sender until every predicted reading has come out.
  task automatic wait_all_readings();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Edges of the window and index range, slot reuse, stray indexes.
  task automatic test_directed();
    send_event(CMD_TICK, 6'd0);          // empty second into slot 0
    send_pulses(3);
    send_event(CMD_TICK, 6'd0);          // overwrite slot 0
    send_event(CMD_TICK, 6'd0);          // same slot right away: forwarding path
    send_event(CMD_PULSE, 6'd63);
    send_event(CMD_TICK, 6'(SLOTS - 1)); // last slot of the window
    send_pulses(2);
    send_event(CMD_TICK, 6'(SLOTS));     // first index past the window
    send_event(CMD_PULSE, 6'd0);
    send_event(CMD_TICK, 6'd63);         // largest index, also stray
    send_event(CMD_TICK, 6'(SLOTS - 1)); // last slot back to back, now empty
    send_pulses(4);
    send_event(CMD_TICK, 6'd1);
    send_event(CMD_TICK, 6'd1);
    send_pulses(1);
    send_event(CMD_TICK, 6'd0);
  endtask

  // Tally pins at 255; the pinned value then leaves the window again.
  task automatic test_saturation();
    send_pulses(258);
    send_event(CMD_TICK, 6'd7);
    send_event(CMD_TICK, 6'd7);
    send_pulses(2);
    send_event(CMD_TICK, 6'd8);
  endtask

  // One well-formed minute: every slot written in order.
  task automatic test_minute_sweep();
    repeat (SLOTS) begin
      send_pulses($urandom_range(6));
      send_event(CMD_TICK, 6'(sweep_sec));
      sweep_sec = (sweep_sec == SLOTS - 1) ? 0 : sweep_sec + 1;
    end
  endtask

  // Mostly well-formed seconds continuing the minute, with some noise:
  // ticks at any index, repeated slots, stray pulse bursts.
  task automatic test_random_mix(input int n_items);
    int               stop_at;
    int               sel;
    logic [IDX_W-1:0] idx;
    stop_at = xfers_sent + n_items;
    while (xfers_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        send_pulses(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6));
        send_event(CMD_TICK, 6'(sweep_sec));
        sweep_sec = (sweep_sec == SLOTS - 1) ? 0 : sweep_sec + 1;
      end else if (sel < 85) begin
        send_event(CMD_TICK, IDX_W'($urandom_range(63)));
      end else if (sel < 93) begin
        idx = IDX_W'($urandom_range(SLOTS - 1));
        send_event(CMD_TICK, idx);
        send_pulses($urandom_range(1));
        send_event(CMD_TICK, idx);
      end else begin
        send_pulses($urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    pulse_tally = '0;
    minute_sum  = '0;
    foreach (slot_counts[i]) slot_counts[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(0, 0);
    test_directed();
    wait_all_readings();  // sender holds until the block has drained

    set_idling(61, 0);
    test_saturation();
    set_idling(0, 61);
    test_minute_sweep();
    wait_all_readings();

    set_idling(0, 0);
    test_random_mix(140);
    set_idling(61, 0);
    test_random_mix(140);
    set_idling(0, 61);
    test_random_mix(140);
    set_idling(23, 23);
    test_random_mix(140);
    set_idling(0, 0);
    test_random_mix(40);

    // drain, then give the two-stage pipe time to show any extra reading
    wait_all_readings();
    repeat (10) @(posedge clk);
    if (pending_readings.size() != 0)
      report_mismatch("readings never delivered", 0, pending_readings.size());

    $display("covered %0d transfers: %0d ticks (%0d past the window), peak tally %0d",
             xfers_sent, ticks_sent, stray_ticks, peak_cps);
    $display("checked %0d readings under four idle/stall mixes, %0d mismatches",
             readings_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
design/prsw_pkg.sv
design/prsw_slot_mem.sv
design/pulse_rate_sliding_window.sv
tb/tb_pulse_rate_sliding_window.sv
